// ===== rtl/core/tlbrf_pkg.sv =====
package tlbrf_pkg;

    localparam int ADDR_W      = 64;
    localparam int SIZE_W      = 64;
    localparam int SHIFT_W     = 6;
    localparam int ID_W        = 16;
    localparam int THR_W       = 7;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [THR_W-1:0]  THRESH_RESET = 7'd64;
    localparam logic [ADDR_W-1:0] ADDR_ONE     = 64'd1;
    localparam logic [CNT_W-1:0]  COUNT_ONE    = 7'd1;

    typedef enum logic [1:0] {
        CMD_PAGE_ID  = 2'd0,
        CMD_PAGE_ANY = 2'd1,
        CMD_ALL_ID   = 2'd2,
        CMD_ALL_ANY  = 2'd3
    } cmd_t;

    // One classified request: a run of count commands starting at addr.
    typedef struct packed {
        cmd_t               cmd;
        logic [ADDR_W-1:0]  addr;
        logic [SHIFT_W-1:0] shift;
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   count;
    } job_t;

endpackage

// ===== rtl/core/tlbrf_if.sv =====
interface tlbrf_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] start_addr;
    logic [63:0] range_size;
    logic        whole_space;
    logic [5:0]  stride_shift;
    logic [15:0] space_id;
    logic        no_space_id;

    modport source (
        output valid, start_addr, range_size, whole_space, stride_shift, space_id,
               no_space_id,
        input  ready
    );
    modport sink (
        input  valid, start_addr, range_size, whole_space, stride_shift, space_id,
               no_space_id,
        output ready
    );
endinterface

interface tlbrf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] target_addr;
    logic [15:0] target_id;
    logic        last;

    modport source (
        output valid, command, target_addr, target_id, last,
        input  ready
    );
    modport sink (
        input  valid, command, target_addr, target_id, last,
        output ready
    );
endinterface

// ===== rtl/core/tlbrf_front.sv =====
module tlbrf_front #(
    parameter int MAX_PAGE_FLUSHES = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    tlbrf_req_if.sink                req,
    input  logic                     cfg_wr_en,
    input  logic [tlbrf_pkg::THR_W-1:0] cfg_wr_data,
    output logic                     push,
    output tlbrf_pkg::job_t          push_job,
    input  logic                     queue_full
);
    import tlbrf_pkg::*;

    localparam logic [THR_W-1:0] MAX_LIMIT = THR_W'(MAX_PAGE_FLUSHES);

    logic [THR_W-1:0]  thr_reg;
    logic [THR_W-1:0]  thr_next;
    logic [THR_W-1:0]  limit;
    logic [ADDR_W-1:0] stride;
    logic [SIZE_W-1:0] quot;
    logic              rem_nz;
    logic              single;
    logic              quot_hi;
    logic [CNT_W:0]    count_lo;
    logic              too_many;
    cmd_t              page_cmd;
    cmd_t              all_cmd;

    always_comb
    begin
        thr_next = cfg_wr_en ? cfg_wr_data : thr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // Page count is ceil(size / stride); only its low bits and an overflow
    // flag matter, since the limit never exceeds the threshold width.
    always_comb
    begin
        stride   = ADDR_ONE << req.stride_shift;
        single   = req.range_size <= stride;
        quot     = req.range_size >> req.stride_shift;
        rem_nz   = |(req.range_size & (stride - ADDR_ONE));
        quot_hi  = |quot[SIZE_W-1:CNT_W];
        count_lo = {1'b0, quot[CNT_W-1:0]} + {{CNT_W{1'b0}}, rem_nz};
        limit    = (thr_reg > MAX_LIMIT) ? MAX_LIMIT : thr_reg;
        too_many = quot_hi | (count_lo > {1'b0, limit});
        page_cmd = req.no_space_id ? CMD_PAGE_ANY : CMD_PAGE_ID;
        all_cmd  = req.no_space_id ? CMD_ALL_ANY : CMD_ALL_ID;

        push_job.shift = req.stride_shift;
        push_job.id    = req.no_space_id ? '0 : req.space_id;
        if (single)
        begin
            push_job.cmd   = page_cmd;
            push_job.addr  = req.start_addr;
            push_job.count = COUNT_ONE;
        end
        else if (req.whole_space || too_many)
        begin
            push_job.cmd   = all_cmd;
            push_job.addr  = '0;
            push_job.count = COUNT_ONE;
        end
        else
        begin
            push_job.cmd   = page_cmd;
            push_job.addr  = req.start_addr;
            push_job.count = count_lo[CNT_W-1:0];
        end
    end

    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;

endmodule

// ===== rtl/core/tlbrf_queue.sv =====
module tlbrf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tlbrf_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output tlbrf_pkg::job_t pop_job,
    output logic            empty
);
    import tlbrf_pkg::*;

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] fill_reg;
    logic [QUEUE_CNT_W-1:0] fill_next;

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QUEUE_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = QUEUE_CNT_W'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = QUEUE_CNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job = mem_reg[rd_ptr_reg];
    assign full    = fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty   = fill_reg == '0;

endmodule

// ===== rtl/core/tlbrf_back.sv =====
module tlbrf_back (
    input  logic            clk,
    input  logic            rst_n,
    output logic            pop,
    input  tlbrf_pkg::job_t pop_job,
    input  logic            empty,
    tlbrf_cmd_if.source     cmd
);
    import tlbrf_pkg::*;

    logic              active_reg, active_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] stride_reg, stride_next;
    logic [ID_W-1:0]   id_reg, id_next;
    cmd_t              out_cmd_reg, out_cmd_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;
    logic              slot_free;
    logic              emit;

    assign slot_free = !out_valid_reg || cmd.ready;
    assign emit      = active_reg && slot_free;
    assign pop       = !active_reg && !empty;

    always_comb
    begin
        active_next    = active_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        stride_next    = stride_reg;
        id_next        = id_reg;
        out_cmd_next   = out_cmd_reg;
        out_addr_next  = out_addr_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;

        if (pop)
        begin
            active_next = 1'b1;
            left_next   = pop_job.count;
            cmd_next    = pop_job.cmd;
            addr_next   = pop_job.addr;
            stride_next = ADDR_ONE << pop_job.shift;
            id_next     = pop_job.id;
        end

        if (slot_free)
        begin
            out_valid_next = emit;
        end

        // Each emitted beat steps the address by one stride, wrapping mod 2^64.
        if (emit)
        begin
            active_next   = left_reg != COUNT_ONE;
            left_next     = CNT_W'(left_reg - 1'b1);
            addr_next     = addr_reg + stride_reg;
            out_cmd_next  = cmd_reg;
            out_addr_next = addr_reg;
            out_id_next   = id_reg;
            out_last_next = left_reg == COUNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        stride_reg   <= stride_next;
        id_reg       <= id_next;
        out_cmd_reg  <= out_cmd_next;
        out_addr_reg <= out_addr_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    assign cmd.valid       = out_valid_reg;
    assign cmd.command     = out_cmd_reg;
    assign cmd.target_addr = out_addr_reg;
    assign cmd.target_id   = out_id_reg;
    assign cmd.last        = out_last_reg;

endmodule

// ===== rtl/core/tlb_range_flush_sequencer_unit.sv =====
// TLB range-flush sequencer. Each request beat on req (start address, size,
// stride shift, address-space id, any-id flag, whole-space flag) becomes one
// or more invalidate command beats on cmd. A range no larger than one stride
// gives one page command; otherwise a whole-space request, or one whose page
// count ceil(size / stride) exceeds the threshold (saturated to
// MAX_PAGE_FLUSHES), gives one flush-all command; otherwise one page command
// is sent per stride step, the address wrapping mod 2^64. The last command of
// each request carries last = 1. Each request is first loaded from the queue
// into the command sequencer, which then sends one command beat per cycle
// while the command side is ready. The classifier takes a request in the
// cycle it is presented whenever the two-entry queue has room, so new
// requests keep arriving while an earlier one is still being expanded. The
// threshold register resets to 64 and is written through cfg_wr_en and
// cfg_wr_data; it should only be changed while no request is in flight.
module tlb_range_flush_sequencer_unit #(
    parameter int MAX_PAGE_FLUSHES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tlbrf_req_if.sink                   req,
    tlbrf_cmd_if.source                 cmd,
    input  logic                        cfg_wr_en,
    input  logic [tlbrf_pkg::THR_W-1:0] cfg_wr_data
);
    import tlbrf_pkg::*;

    // Front to queue: classified request and back-pressure.
    logic push;
    job_t push_job;
    logic queue_full;

    // Queue to back: next request to expand into command beats.
    logic pop;
    job_t pop_job;
    logic queue_empty;

    tlbrf_front #(
        .MAX_PAGE_FLUSHES (MAX_PAGE_FLUSHES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_job    (push_job),
        .queue_full  (queue_full)
    );

    tlbrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    // The back end walks the page run and owns the output register, so a
    // stalled command beat blocks new requests only once the queue is full.
    tlbrf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop     (pop),
        .pop_job (pop_job),
        .empty   (queue_empty),
        .cmd     (cmd)
    );

endmodule

// ===== test/tlbrf_flush_checker.sv =====
`timescale 1ns / 100ps

// Watches the request and command channels, expands every accepted request
// into the command beats it should produce, and compares the command beats
// that the block sends against them in order.
module tlbrf_flush_checker #(
    parameter int MAX_PAGE_FLUSHES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tlbrf_req_if                        req,
    tlbrf_cmd_if                        cmd,
    input  logic                        cfg_wr_en,
    input  logic [tlbrf_pkg::THR_W-1:0] cfg_wr_data,
    output int                          mismatches,
    output int                          pending_beats
);
    import tlbrf_pkg::*;

    typedef struct {
        cmd_t              command;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   id;
        logic              last;
    } flush_beat_t;

    flush_beat_t expected_beats[$];

    logic [THR_W-1:0]  flush_limit;

    function automatic void queue_beat(cmd_t command, logic [ADDR_W-1:0] addr,
                                       logic [ID_W-1:0] id, logic last);
        flush_beat_t b;
        b.command = command;
        b.addr    = addr;
        b.id      = id;
        b.last    = last;
        expected_beats.push_back(b);
    endfunction

    function automatic void expand_request(logic [ADDR_W-1:0] start,
                                           logic [SIZE_W-1:0] size,
                                           logic whole, logic [SHIFT_W-1:0] shift,
                                           logic [ID_W-1:0] sid, logic any);
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] pages;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   id_out;
        logic [THR_W-1:0]  cap;
        cmd_t              page_cmd;
        cmd_t              all_cmd;

        stride   = ADDR_ONE << shift;
        id_out   = any ? '0 : sid;
        page_cmd = any ? CMD_PAGE_ANY : CMD_PAGE_ID;
        all_cmd  = any ? CMD_ALL_ANY : CMD_ALL_ID;

        // The size test wins over the whole-space flag.
        if (size <= stride)
        begin
            queue_beat(page_cmd, start, id_out, 1'b1);
            return;
        end
        if (whole)
        begin
            queue_beat(all_cmd, '0, id_out, 1'b1);
            return;
        end

        pages = (size >> shift) + ADDR_W'((size & (stride - 1)) != 0);
        cap   = (flush_limit > MAX_PAGE_FLUSHES) ? THR_W'(MAX_PAGE_FLUSHES) : flush_limit;
        if (pages > cap)
        begin
            queue_beat(all_cmd, '0, id_out, 1'b1);
            return;
        end

        addr = start;
        for (int i = 0; i < pages; i++)
        begin
            queue_beat(page_cmd, addr, id_out, (ADDR_W'(i) + 1) == pages);
            addr = addr + stride;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flush_beat_t want;
        if (!rst_n)
        begin
            flush_limit <= THRESH_RESET;
            expected_beats.delete();
            mismatches    <= 0;
            pending_beats <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                flush_limit <= cfg_wr_data;

            if (req.valid && req.ready)
                expand_request(req.start_addr, req.range_size, req.whole_space,
                               req.stride_shift, req.space_id, req.no_space_id);

            if (cmd.valid && cmd.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("mismatch: unexpected beat cmd=%0d addr=%h id=%h last=%b",
                                 cmd.command, cmd.target_addr, cmd.target_id, cmd.last);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (cmd.command !== want.command || cmd.target_addr !== want.addr ||
                        cmd.target_id !== want.id || cmd.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: expected cmd=%0d addr=%h id=%h last=%b,",
                                      " got cmd=%0d addr=%h id=%h last=%b"},
                                     want.command, want.addr, want.id, want.last,
                                     cmd.command, cmd.target_addr, cmd.target_id,
                                     cmd.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            pending_beats <= expected_beats.size();
        end
    end

endmodule

// ===== test/tlb_range_flush_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps

// Top of the testbench for the range-flush sequencer. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts every
// command beat and counts mismatches.
module tlb_range_flush_sequencer_unit_tb;
    import tlbrf_pkg::*;

    localparam int MAX_FLUSHES    = 64;
    localparam int CYCLE_LIMIT    = 10_000_000;
    // The long hold-off of the command side; it is far longer than one full
    // expansion, so the two-entry queue fills and the request side stalls.
    localparam int SQUEEZE_CYCLES = 400;
    localparam int SQUEEZE_ITEMS  = 12;
    // Wait after the last expected beat, long enough for the block to show a
    // stray beat if it has one.
    localparam int SETTLE_CYCLES  = 30;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    // Phase controls, written by the stimulus and read by the command side.
    logic full_rate   = 1'b0;
    logic squeeze_req = 1'b0;

    // Effective page limit of the current phase; it only steers the random
    // page counts toward the threshold edge.
    int thr_now;
    int mismatches;
    int pending_beats;
    int cycles;

    tlbrf_req_if req_ch();
    tlbrf_cmd_if cmd_ch();

    tlb_range_flush_sequencer_unit #(
        .MAX_PAGE_FLUSHES(MAX_FLUSHES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .cmd        (cmd_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    tlbrf_flush_checker #(
        .MAX_PAGE_FLUSHES(MAX_FLUSHES)
    ) flush_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .cmd          (cmd_ch),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .pending_beats(pending_beats)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Offers one request beat and returns at the edge where it is accepted.
    // Valid stays high into the next call when no gap is drawn, so the block
    // sees back-to-back beats.
    task automatic send_request(input logic [63:0] start, input logic [63:0] size,
                                input logic whole, input logic [5:0] shift,
                                input logic [15:0] sid, input logic any);
        int gap;
        gap = full_rate ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.start_addr   <= start;
        req_ch.range_size   <= size;
        req_ch.whole_space  <= whole;
        req_ch.stride_shift <= shift;
        req_ch.space_id     <= sid;
        req_ch.no_space_id  <= any;
        req_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Random request. Most are well-formed multi-page ranges with a page count
    // either small or close to the current threshold; the rest are single
    // pages, whole-space requests and raw sizes that land on a flush-all.
    task automatic send_random_request();
        logic [63:0] start;
        logic [63:0] size;
        logic [63:0] stride;
        logic [5:0]  shift;
        logic [15:0] sid;
        logic        whole;
        logic        any;
        int          kind;
        int          pages;
        int          lo;

        start  = rand64();
        sid    = 16'($urandom_range(0, 65535));
        any    = ($urandom_range(0, 3) == 0);
        // Shifts outside the normal page sizes are legal and taken as given.
        shift  = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(12, 39))
                                             : 6'($urandom_range(0, 63));
        stride = 64'd1 << shift;
        whole  = 1'b0;
        kind   = $urandom_range(0, 99);

        if (kind < 20)
        begin
            size  = ($urandom_range(0, 3) == 0) ? stride : (rand64() & (stride - 1));
            whole = ($urandom_range(0, 2) == 0);
        end
        else if (kind < 80)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                lo    = (thr_now - 2 < 2) ? 2 : thr_now - 2;
                pages = $urandom_range(lo, thr_now + 2);
            end
            else
                pages = $urandom_range(2, 10);
            // Partial last page: anywhere from one byte to a full stride.
            size  = (64'(pages - 1) << shift) + (rand64() & (stride - 1)) + 64'd1;
            whole = ($urandom_range(0, 9) == 0);
        end
        else if (kind < 90)
        begin
            size  = rand64();
            whole = 1'b1;
        end
        else
        begin
            size  = rand64();
            whole = 1'($urandom_range(0, 1));
        end

        send_request(start, size, whole, shift, sid, any);
    endtask

    // Drops valid and waits until the checker holds no expected beat, which
    // means every request has been fully expanded and the block is idle.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    task automatic program_threshold(input logic [THR_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thr_now = (value > MAX_FLUSHES) ? MAX_FLUSHES : value;
    endtask

    // Command side. A random ready pattern, always ready in full-rate phases,
    // and one long hold-off when the stimulus asks for it.
    initial
    begin
        int gap;
        bit squeezed;
        squeezed = 1'b0;
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                cmd_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else if (full_rate)
            begin
                cmd_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                gap = idle_gap();
                if (gap == 0)
                begin
                    cmd_ch.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    cmd_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: a hung handshake or an expected beat that never comes ends
    // the run here.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tlb_range_flush_sequencer_unit verification failed");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.start_addr   <= '0;
        req_ch.range_size   <= '0;
        req_ch.whole_space  <= 1'b0;
        req_ch.stride_shift <= '0;
        req_ch.space_id     <= '0;
        req_ch.no_space_id  <= 1'b0;
        thr_now = MAX_FLUSHES;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset threshold.
        // Zero size gives one page command, here at the top of the address space.
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 6'd12, 16'hFFFF, 1'b0);
        // Size equal to the stride with the whole-space flag: still one page.
        send_request(64'd0, 64'd4096, 1'b1, 6'd12, 16'h0000, 1'b1);
        // Whole-space flag on a multi-page range, for one id and for any id.
        send_request(64'h0000_0000_1234_5000, 64'h10_0000, 1'b1, 6'd12, 16'hA5A5, 1'b0);
        send_request(64'h0000_0000_1234_5000, 64'h10_0000, 1'b1, 6'd12, 16'hA5A5, 1'b1);
        // Exactly 64 pages, starting one page below the top so the address wraps.
        send_request(64'hFFFF_FFFF_FFFF_F000, 64'd64 * 64'd4096, 1'b0, 6'd12, 16'h5A5A,
                     1'b0);
        // One byte more rounds up to 65 pages: flush-all.
        send_request(64'hFFFF_FFFF_FFFF_F000, 64'd64 * 64'd4096 + 64'd1, 1'b0, 6'd12,
                     16'h5A5A, 1'b1);
        // Largest size at the smallest normal stride.
        send_request(rand64(), 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd12, 16'h0001, 1'b0);
        // Stride of one byte.
        send_request(64'd5, 64'd3, 1'b0, 6'd0, 16'h8000, 1'b0);
        // Largest stride: two pages, the second wrapping to zero.
        send_request(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd63,
                     16'h7FFF, 1'b0);
        // Largest normal stride, two whole pages.
        send_request(64'd0, 64'h100_0000_0000, 1'b0, 6'd39, 16'h1234, 1'b1);
        send_request(64'hC000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd62,
                     16'h4321, 1'b0);
        // Partial last page and an exact multiple of the stride.
        send_request(rand64(), 64'd4097, 1'b0, 6'd12, 16'h00FF, 1'b0);
        send_request(rand64(), 64'd3 * 64'd4096, 1'b0, 6'd12, 16'hFF00, 1'b1);
        send_request(rand64(), 64'd0, 1'b1, 6'd63, 16'hFFFF, 1'b1);

        repeat (100) send_random_request();

        // Threshold of zero: every multi-page range turns into a flush-all.
        program_threshold(7'd0);
        send_request(rand64(), 64'd4097, 1'b0, 6'd12, 16'h2468, 1'b0);
        send_request(rand64(), 64'd4096, 1'b0, 6'd12, 16'h2468, 1'b0);
        send_request(rand64(), 64'd0, 1'b0, 6'd12, 16'h1357, 1'b1);
        repeat (50) send_random_request();

        program_threshold(7'd1);
        send_request(rand64(), 64'd8192, 1'b0, 6'd12, 16'hBEEF, 1'b0);
        send_request(rand64(), 64'd4096, 1'b0, 6'd12, 16'hBEEF, 1'b1);
        repeat (50) send_random_request();

        // Largest register value, which saturates to the page-flush maximum.
        program_threshold(7'd127);
        send_request(rand64(), 64'd64 * 64'd65536, 1'b0, 6'd16, 16'hCAFE, 1'b1);
        send_request(rand64(), 64'd64 * 64'd65536 + 64'd1, 1'b0, 6'd16, 16'hCAFE, 1'b0);

        // Command side holds off for a long stretch while requests keep coming
        // back to back, so the queue fills and the request side stalls.
        req_ch.valid <= 1'b0;
        squeeze_req  <= 1'b1;
        full_rate    <= 1'b1;
        @(posedge clk);
        repeat (SQUEEZE_ITEMS) send_random_request();
        full_rate   <= 1'b0;
        repeat (60 - SQUEEZE_ITEMS) send_random_request();

        // Small threshold with no idling on either side.
        program_threshold(7'd5);
        full_rate <= 1'b1;
        @(posedge clk);
        repeat (60) send_random_request();
        full_rate <= 1'b0;

        program_threshold(THRESH_RESET);
        repeat (40) send_random_request();

        program_threshold(7'($urandom_range(0, 127)));
        repeat (40) send_random_request();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tlb_range_flush_sequencer_unit verification clean");
        else
            $display("tlb_range_flush_sequencer_unit verification failed");
        $finish;
    end

endmodule
